### rtl/krta_pkg.sv
// ----------------------------------------------------------------------------
// krta_pkg
// Shared types and constants for the keyed reading table average block.
// ----------------------------------------------------------------------------
package krta_pkg;

    localparam int ADDR_HALF_W = 64;
    localparam int KEY_W       = 2 * ADDR_HALF_W;
    localparam int READING_W   = 8;

    // Main sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_UPD   = 7'b0001000,
        S_START = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_PUSH  = 7'b1000000
    } t_state;

endpackage

### rtl/krta_ram.sv
// ----------------------------------------------------------------------------
// krta_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module krta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/krta_div.sv
// ----------------------------------------------------------------------------
// krta_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module krta_div #(
    parameter int DIVIDEND_W = 12,
    parameter int DIVISOR_W  = 5,
    parameter int QUOTIENT_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [QUOTIENT_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_dvs, n_dvs;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  take;

    always_comb begin
        shifted = {r_rem, r_quo[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        take    = (shifted >= {1'b0, r_dvs});
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIVIDEND_W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // Shift in the next dividend bit, subtract when it fits
            n_rem = take ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            n_quo = {r_quo[DIVIDEND_W-2:0], take};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[QUOTIENT_W-1:0];

endmodule

### rtl/keyed_reading_table_average.sv
// Latency: grows with the number of entries compared and with the sum width; a miss or a
//   full table compares every stored entry before the divide starts.
// Throughput: one beat at a time; no new input is taken until the result is loaded into the
//   output register. The key search and the bit-serial divide set the time per beat.
// Reset: synchronous, active low; the table empties, the sum clears, no result pending.
// ----------------------------------------------------------------------------
// keyed_reading_table_average
// Table of node readings keyed by 128-bit address, reporting the floor of the
// mean of all stored readings after every update.
// ----------------------------------------------------------------------------
module keyed_reading_table_average #(
    parameter int ENTRIES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [krta_pkg::ADDR_HALF_W-1:0] i_address_high,
    input  logic [krta_pkg::ADDR_HALF_W-1:0] i_address_low,
    input  logic [krta_pkg::READING_W-1:0]   i_reading,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [krta_pkg::READING_W-1:0]   o_mean_reading,
    output logic                           o_table_full
);

    // Entry count spans 0..ENTRIES; the index spans the table itself.
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // Exact sum of up to ENTRIES readings of 255
    localparam int SW = $clog2(ENTRIES * 255 + 1);

    krta_pkg::t_state r_state, n_state;

    // Entries are never freed, so the valid entries are always 0..count-1 and
    // the lowest free entry is the count itself.
    logic [CW-1:0]                  r_count, n_count;
    logic [SW-1:0]                  r_sum, n_sum;
    logic [CW-1:0]                  r_idx, n_idx;
    logic                           r_hit, n_hit;
    logic                           r_full, n_full;
    logic [krta_pkg::KEY_W-1:0]     r_key, n_key;
    logic [krta_pkg::READING_W-1:0] r_val, n_val;
    logic                           r_out_valid, n_out_valid;
    logic [krta_pkg::READING_W-1:0] r_mean, n_mean;
    logic                           r_out_full, n_out_full;

    logic [krta_pkg::KEY_W-1:0]     key_rdata;
    logic [krta_pkg::READING_W-1:0] val_rdata;
    logic                           key_we;
    logic                           val_we;
    logic                           div_start;
    logic                           div_done;
    logic [krta_pkg::READING_W-1:0] div_quo;
    logic                           has_free;
    logic                           out_free;

    assign has_free  = (r_count < CW'(ENTRIES));
    assign out_free  = !r_out_valid || i_out_ready;
    assign div_start = (r_state == krta_pkg::S_START);
    assign key_we    = (r_state == krta_pkg::S_UPD) && !r_hit && has_free;
    assign val_we    = (r_state == krta_pkg::S_UPD) && (r_hit || has_free);

    // Key store: both address halves side by side
    krta_ram #(
        .WIDTH (krta_pkg::KEY_W),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_idx[IW-1:0]),
        .i_wdata (r_key),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (key_rdata)
    );

    krta_ram #(
        .WIDTH (krta_pkg::READING_W),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_idx[IW-1:0]),
        .i_wdata (r_val),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (val_rdata)
    );

    krta_div #(
        .DIVIDEND_W (SW),
        .DIVISOR_W  (CW),
        .QUOTIENT_W (krta_pkg::READING_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sum       = r_sum;
        n_idx       = r_idx;
        n_hit       = r_hit;
        n_full      = r_full;
        n_key       = r_key;
        n_val       = r_val;
        n_out_valid = r_out_valid;
        n_mean      = r_mean;
        n_out_full  = r_out_full;

        // Drop the result once the sink takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            krta_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_key   = {i_address_high, i_address_low};
                    n_val   = i_reading;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_full  = 1'b0;
                    n_state = krta_pkg::S_SCAN;
                end
            end
            krta_pkg::S_SCAN: begin
                // Read address is r_idx; end of valid entries means a miss
                if (r_idx == r_count) begin
                    n_state = krta_pkg::S_UPD;
                end else begin
                    n_state = krta_pkg::S_CMP;
                end
            end
            krta_pkg::S_CMP: begin
                if (key_rdata == r_key) begin
                    n_hit   = 1'b1;
                    // Take the old reading out of the sum now
                    n_sum   = r_sum - SW'(val_rdata);
                    n_state = krta_pkg::S_UPD;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = krta_pkg::S_SCAN;
                end
            end
            krta_pkg::S_UPD: begin
                if (r_hit) begin
                    n_sum = r_sum + SW'(r_val);
                end else if (has_free) begin
                    n_sum   = r_sum + SW'(r_val);
                    n_count = r_count + CW'(1);
                end else begin
                    n_full = 1'b1;
                end
                n_state = krta_pkg::S_START;
            end
            krta_pkg::S_START: begin
                n_state = krta_pkg::S_DIV;
            end
            krta_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = krta_pkg::S_PUSH;
                end
            end
            krta_pkg::S_PUSH: begin
                // Hold until the output register is free
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_mean      = (r_count == '0) ? '0 : div_quo;
                    n_out_full  = r_full;
                    n_state     = krta_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = krta_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= krta_pkg::S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_full      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_hit       <= n_hit;
            r_full      <= n_full;
        end
        r_key      <= n_key;
        r_val      <= n_val;
        r_mean     <= n_mean;
        r_out_full <= n_out_full;
    end

    assign o_in_ready     = (r_state == krta_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_mean_reading = r_mean;
    assign o_table_full   = r_out_full;

endmodule

### rtl/krta_checker.sv
// ----------------------------------------------------------------------------
// krta_checker
// Port-level checks for keyed_reading_table_average, bound to the top level.
// ----------------------------------------------------------------------------
module krta_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [krta_pkg::READING_W-1:0] o_mean_reading,
    input logic                         o_table_full
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_mean_reading) && $stable(o_table_full))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // Busy once an input beat is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accepting a beat");

    // A new result only follows work in progress
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without an item in progress");

endmodule

bind keyed_reading_table_average krta_checker u_krta_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_mean_reading (o_mean_reading),
    .o_table_full   (o_table_full)
);

### tb/sv/keyed_reading_table_average_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_reading_table_average_test
// Self-checking bench for the keyed reading table average block. A scoreboard
// mirrors the address-keyed table and the running sum. It predicts the mean
// and the full flag of every input beat and checks each output beat in order.
// Stimulus fills the table with edge-case keys and then drives mostly hits on
// stored nodes, near-miss and fresh addresses, and full-table sweeps, while
// both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module keyed_reading_table_average_test;

    localparam int          ADDR_HALF_W  = krta_pkg::ADDR_HALF_W;
    localparam int          READING_W    = krta_pkg::READING_W;
    localparam int          ENTRIES      = 16;
    localparam int          RESET_CYCLES = 7;
    localparam int unsigned RANDOM_ITEMS = 1830;
    // Hold the receiver off long enough to stall the input side many times over.
    localparam int unsigned LONG_HOLD    = 400;
    // Give the tail a wide margin over the worst latency.
    localparam int unsigned DRAIN_CYCLES = 120;
    // Cycles without any accepted beat before the run is declared hung.
    localparam int unsigned STALL_LIMIT  = 4000;

    typedef struct {
        logic [READING_W-1:0] mean_reading;
        logic                 table_full;
    } t_mean_beat;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the key table, the stored readings and the sum.
    // ------------------------------------------------------------------------
    class mean_scoreboard;
        logic [ADDR_HALF_W-1:0] key_high [ENTRIES];
        logic [ADDR_HALF_W-1:0] key_low  [ENTRIES];
        logic [READING_W-1:0]   stored   [ENTRIES];
        bit                     occupied [ENTRIES];
        int unsigned            entry_count;
        int unsigned            reading_sum;
        t_mean_beat             expected_means[$];
        int unsigned            mismatches;
        int unsigned            results_seen;

        function new();
            foreach (occupied[i]) occupied[i] = 1'b0;
            entry_count  = 0;
            reading_sum  = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int unsigned pending();
            return expected_means.size();
        endfunction

        // Update the table for one accepted input beat and queue its result.
        function void note_reading(input logic [ADDR_HALF_W-1:0] addr_high,
                                   input logic [ADDR_HALF_W-1:0] addr_low,
                                   input logic [READING_W-1:0]   reading);
            int         hit;
            int         free_slot;
            t_mean_beat predicted;
            hit       = -1;
            free_slot = -1;
            predicted.table_full = 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                if (occupied[i]) begin
                    if (hit < 0 && key_high[i] == addr_high && key_low[i] == addr_low)
                        hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (hit >= 0) begin
                reading_sum = reading_sum - stored[hit] + reading;
                stored[hit] = reading;
            end else if (free_slot >= 0) begin
                key_high[free_slot] = addr_high;
                key_low[free_slot]  = addr_low;
                stored[free_slot]   = reading;
                occupied[free_slot] = 1'b1;
                entry_count++;
                reading_sum += reading;
            end else begin
                predicted.table_full = 1'b1;
            end
            predicted.mean_reading = (entry_count != 0) ?
                READING_W'(reading_sum / entry_count) : '0;
            expected_means.push_back(predicted);
        endfunction

        task report(input string what);
            mismatches++;
            $display("[%0t] MISMATCH %s", $time, what);
        endtask

        // Compare one accepted output beat with the oldest prediction.
        task check_mean(input logic [READING_W-1:0] mean_reading, input logic table_full);
            t_mean_beat predicted;
            results_seen++;
            if (expected_means.size() == 0) begin
                report($sformatf("unexpected result: mean %0d full %b",
                                 mean_reading, table_full));
                return;
            end
            predicted = expected_means.pop_front();
            if (mean_reading !== predicted.mean_reading)
                report($sformatf("result %0d: mean_reading %0d, expected %0d",
                                 results_seen, mean_reading, predicted.mean_reading));
            if (table_full !== predicted.table_full)
                report($sformatf("result %0d: table_full %b, expected %b",
                                 results_seen, table_full, predicted.table_full));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [ADDR_HALF_W-1:0] i_address_high;
    logic [ADDR_HALF_W-1:0] i_address_low;
    logic [READING_W-1:0]   i_reading;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [READING_W-1:0]   o_mean_reading;
    logic                   o_table_full;

    mean_scoreboard sb;
    bit             sender_calm;

    keyed_reading_table_average #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_address_high(i_address_high),
        .i_address_low (i_address_low),
        .i_reading     (i_reading),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_mean_reading(o_mean_reading),
        .o_table_full  (o_table_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Idle length: mostly none or short, now and then a long gap.
    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ADDR_HALF_W-1:0] random_half();
        return {$urandom, $urandom};
    endfunction

    // Offer one beat and hold it until accepted. Drop valid only when a gap
    // follows, so back-to-back beats keep valid high without a glitch.
    task automatic send_reading(input logic [ADDR_HALF_W-1:0] addr_high,
                                input logic [ADDR_HALF_W-1:0] addr_low,
                                input logic [READING_W-1:0]   reading);
        int unsigned gap;
        gap = sender_calm ? 0 : idle_length();
        i_in_valid     <= 1'b1;
        i_address_high <= addr_high;
        i_address_low  <= addr_low;
        i_reading      <= reading;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sample both handshakes at the clock edge. Check the result before noting
    // the input of the same edge: that input's result cannot be out yet.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_ready)
                sb.check_mean(o_mean_reading, o_table_full);
            if (i_in_valid && o_in_ready === 1'b1)
                sb.note_reading(i_address_high, i_address_low, i_reading);
        end
    end

    // Receiver: random stalls, calm stretches, and one long hold-off once the
    // run is well under way so the block backs up and stalls its input.
    initial begin : receiver
        int unsigned stall_left;
        int unsigned cycles;
        bit          long_hold_done;
        stall_left     = 0;
        cycles         = 0;
        long_hold_done = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (!long_hold_done && sb.results_seen >= 150) begin
                stall_left     = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (stall_left == 0 && (cycles / 700) % 3 != 2 && $urandom_range(0, 9) < 3)
                stall_left = idle_length();
            if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int unsigned            sent;
        int unsigned            pick;
        int unsigned            idx;
        int unsigned            bit_pos;
        bit                     drained;
        logic [ADDR_HALF_W-1:0] addr_high;
        logic [ADDR_HALF_W-1:0] addr_low;
        logic [READING_W-1:0]   reading;

        sb          = new();
        sender_calm = 1'b0;
        drained     = 1'b0;
        sent        = 0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_address_high <= '0;
        i_address_low  <= '0;
        i_reading      <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: all-zero and all-one keys, keys that differ in one half only,
        // overwrite of a stored node, then fill the table and overflow it.
        send_reading('0, '0, 8'd0);
        send_reading('1, '1, 8'd255);
        send_reading('0, '1, 8'd255);
        send_reading('1, '0, 8'd0);
        send_reading('0, '0, 8'd255);
        send_reading('1, '1, 8'd0);
        send_reading('0, 64'd1, 8'd1);
        send_reading({1'b1, 63'd0}, '0, 8'd128);
        repeat (ENTRIES - 6)
            send_reading(random_half(), random_half(), READING_W'($urandom_range(0, 255)));
        // Table is full now: a fresh address is dropped with the flag raised.
        send_reading(random_half(), random_half(), 8'd77);
        // Hit on the last slot searched, then a key matching only the high half.
        send_reading(sb.key_high[ENTRIES-1], sb.key_low[ENTRIES-1], 8'd255);
        send_reading(sb.key_high[3], ~sb.key_low[3], 8'd200);

        // Random: mostly hits on stored nodes with random readings, plus
        // near-miss keys, fresh keys and whole-table sweeps to one value.
        while (sent < RANDOM_ITEMS) begin
            sender_calm = ((sent / 150) % 3 == 1);
            if (!drained && sent >= RANDOM_ITEMS / 2) begin
                // Pause the sender until every queued result is out; step past a clock
                // edge first so the last accepted beat is already noted.
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                case ($urandom_range(0, 2))
                    0:       reading = 8'd0;
                    1:       reading = 8'd255;
                    default: reading = READING_W'($urandom_range(0, 255));
                endcase
                for (int k = 0; k < ENTRIES; k++)
                    send_reading(sb.key_high[k], sb.key_low[k], reading);
                sent += ENTRIES;
            end else begin
                idx       = $urandom_range(0, sb.entry_count - 1);
                addr_high = sb.key_high[idx];
                addr_low  = sb.key_low[idx];
                if ($urandom_range(0, 99) < 15)
                    reading = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                else
                    reading = READING_W'($urandom_range(0, 255));
                if (pick >= 85) begin
                    addr_high = random_half();
                    addr_low  = random_half();
                end else if (pick >= 70) begin
                    // Flip one bit of a stored key.
                    bit_pos = $urandom_range(0, ADDR_HALF_W - 1);
                    if ($urandom_range(0, 1))
                        addr_high[bit_pos] = ~addr_high[bit_pos];
                    else
                        addr_low[bit_pos] = ~addr_low[bit_pos];
                end
                send_reading(addr_high, addr_low, reading);
                sent++;
            end
        end
        i_in_valid <= 1'b0;

        // Drain: wait out every prediction, then watch for stray results.
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
